/* rtl/dvft_pkg.sv */
package dvft_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 16;
  localparam int ENTRY_W = VALUE_W + COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

/* rtl/dvft_ram.sv */
module dvft_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4,
  parameter int DEPTH  = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/distinct_value_frequency_table_core.sv */
// Flow: an input word is accepted in idle; unless the table is empty, the entries are then
//   scanned in order, each with a read state and a compare state; a match ends the scan early.
// Input: one word at a time; no new word is taken until the scan for the last one is done.
// End of list: each entry is read, loaded into the output register and held until taken.
// Reset: synchronous, active low; clears the fill count, overflow flag and control state.
//   The entry RAM is not cleared: only entries below the fill count are ever read.
module distinct_value_frequency_table_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [dvft_pkg::VALUE_W-1:0] in_sample_value,
  input  logic                             in_ends_list,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [dvft_pkg::VALUE_W-1:0] out_entry_value,
  output logic        [dvft_pkg::COUNT_W-1:0] out_entry_count,
  output logic                             out_is_last_entry,
  output logic                             out_overflowed
);

  import dvft_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SCAN_RD   = 6'b000010,
    ST_SCAN_CMP  = 6'b000100,
    ST_EMIT_RD   = 6'b001000,
    ST_EMIT_LD   = 6'b010000,
    ST_EMIT_WAIT = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [VALUE_W-1:0] sample_r, sample_nxt;
  logic               last_r, last_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic               ovf_r, ovf_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [VALUE_W-1:0] rd_value;
  logic [COUNT_W-1:0] rd_count;
  logic               scan_end;

  dvft_ram #(
    .DATA_W (ENTRY_W),
    .ADDR_W (IDX_W),
    .DEPTH  (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign rd_value = ram_rdata[ENTRY_W-1:COUNT_W];
  assign rd_count = ram_rdata[COUNT_W-1:0];
  assign scan_end = ((CNT_W'(idx_r) + CNT_W'(1)) == used_r);

  // A write lands at the edge closing its state; the next read is sampled at the edge closing a
  // later state, so no access can see stale data and no forwarding is needed.
  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = used_r[IDX_W-1:0];
    ram_wdata     = {sample_r, COUNT_W'(1)};

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_sample_value;
          last_nxt   = in_ends_list;
          idx_nxt    = '0;
          if (used_r == '0) begin
            // empty table: append straight away
            ram_we    = 1'b1;
            ram_wdata = {in_sample_value, COUNT_W'(1)};
            used_nxt  = CNT_W'(1);
            state_nxt = in_ends_list ? ST_EMIT_RD : ST_IDLE;
          end else begin
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (rd_value == sample_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r;
          ram_wdata = {rd_value, (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_W'(1)};
          idx_nxt   = '0;
          state_nxt = last_r ? ST_EMIT_RD : ST_IDLE;
        end else if (scan_end) begin
          if (used_r < CNT_W'(TABLE_DEPTH)) begin
            ram_we   = 1'b1;
            used_nxt = used_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          idx_nxt   = '0;
          state_nxt = last_r ? ST_EMIT_RD : ST_IDLE;
        end else begin
          idx_nxt   = IDX_W'(idx_r + 1'b1);
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_value;
        out_count_nxt = rd_count;
        out_last_nxt  = scan_end;
        out_ovf_nxt   = ovf_r;
        state_nxt     = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            // table emptied: drop the entries and the overflow flag
            used_nxt  = '0;
            ovf_nxt   = 1'b0;
            idx_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = IDX_W'(idx_r + 1'b1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r    <= sample_nxt;
    last_r      <= last_nxt;
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_entry_value   = $signed(out_value_r);
  assign out_entry_count   = out_count_r;
  assign out_is_last_entry = out_last_r;
  assign out_overflowed    = out_ovf_r;

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while an entry is pending");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_is_last_entry) |=> (used_r == '0 && !ovf_r))
    else $error("table not cleared after final entry");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_CMP || state_r == ST_EMIT_LD) |-> (CNT_W'(idx_r) < used_r))
    else $error("read beyond filled entries");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_is_last_entry) |=> (state_r == ST_EMIT_RD))
    else $error("emission stopped before final entry");

endmodule

/* dv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dvft_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [COUNT_W-1:0] count;
    logic                      is_last;
    logic                      ovf;
  } entry_t;

  class freq_table_tracker;
    logic signed [VALUE_W-1:0] seen_values [TABLE_DEPTH];
    logic        [COUNT_W-1:0] seen_counts [TABLE_DEPTH];
    int unsigned fill;
    bit dropped;
    entry_t due_entries[$];
    int unsigned errors;
    int unsigned words_noted;
    int unsigned lists_closed;
    int unsigned entries_checked;
    int unsigned overflow_lists;

    function void note_word(logic signed [VALUE_W-1:0] v, logic ends);
      entry_t e;
      bit hit;
      hit = 0;
      words_noted++;
      for (int k = 0; k < fill; k++) begin
        if (seen_values[k] == v) begin
          if (seen_counts[k] != COUNT_MAX) seen_counts[k]++;
          hit = 1;
          break;
        end
      end
      if (!hit) begin
        if (fill < TABLE_DEPTH) begin
          seen_values[fill] = v;
          seen_counts[fill] = 1;
          fill++;
        end else begin
          dropped = 1;
        end
      end
      if (ends) begin
        // emit the whole table in order of first appearance, then clear it
        for (int k = 0; k < fill; k++) begin
          e.value   = seen_values[k];
          e.count   = seen_counts[k];
          e.is_last = (k == fill - 1);
          e.ovf     = dropped;
          due_entries.insert(due_entries.size(), e);
        end
        if (dropped) overflow_lists++;
        lists_closed++;
        fill = 0;
        dropped = 0;
      end
    endfunction

    function void check_entry(logic signed [VALUE_W-1:0] v, logic [COUNT_W-1:0] c,
                              logic il, logic ov);
      entry_t want;
      if (due_entries.size() == 0) begin
        $error("entry %0d (count %0d) arrived with none expected", v, c);
        errors++;
        return;
      end
      want = due_entries.pop_front();
      entries_checked++;
      if (v !== want.value) begin
        $error("entry_value: expected %0d, got %0d", want.value, v);
        errors++;
      end
      if (c !== want.count) begin
        $error("entry_count: expected %0d, got %0d", want.count, c);
        errors++;
      end
      if (il !== want.is_last) begin
        $error("is_last_entry: expected %0d, got %0d", want.is_last, il);
        errors++;
      end
      if (ov !== want.ovf) begin
        $error("overflowed: expected %0d, got %0d", want.ovf, ov);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return due_entries.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] in_sample_value;
  logic                      in_ends_list;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [VALUE_W-1:0] out_entry_value;
  logic        [COUNT_W-1:0] out_entry_count;
  logic                      out_is_last_entry;
  logic                      out_overflowed;

  freq_table_tracker table_tracker = new;
  int unsigned tx_idle_pct = 14;
  int unsigned rx_idle_pct = 46;
  int unsigned cycle_count = 0;

  distinct_value_frequency_table_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_value   (in_sample_value),
    .in_ends_list      (in_ends_list),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_entry_value   (out_entry_value),
    .out_entry_count   (out_entry_count),
    .out_is_last_entry (out_is_last_entry),
    .out_overflowed    (out_overflowed)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d entries still due", cycle_count,
               table_tracker.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: check each accepted entry, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      table_tracker.check_entry(out_entry_value, out_entry_count, out_is_last_entry,
                                out_overflowed);
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic ends);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid        <= 1'b1;
    in_sample_value <= v;
    in_ends_list    <= ends;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    table_tracker.note_word(v, ends);
  endtask

  // hold the sender off until every due entry has come back
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (table_tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] edges [5];
    edges = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1, 32'sd1};
    if ($urandom_range(7) == 0) return edges[$urandom_range(4)];
    return $urandom;
  endfunction

  task automatic send_random_list;
    logic signed [VALUE_W-1:0] pool[$];
    int unsigned kind;
    int unsigned len;
    int unsigned n_distinct;
    kind = $urandom_range(99);
    if (kind < 65) begin
      len = $urandom_range(10, 1);
      n_distinct = $urandom_range(len, 1);
    end else if (kind < 90) begin
      len = $urandom_range(50, 11);
      n_distinct = $urandom_range(40, 1);
    end else begin
      // long lists with a wide pool tend to fill the table
      len = $urandom_range(140, 60);
      n_distinct = $urandom_range(90, 50);
    end
    repeat (n_distinct) pool.insert(pool.size(), pick_value());
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(9) == 0)
        send_word(pick_value(), k == len - 1);
      else
        send_word(pool[$urandom_range(n_distinct - 1)], k == len - 1);
    end
  endtask

  task automatic run_random(input int unsigned word_target);
    while (table_tracker.words_noted < word_target) send_random_list();
  endtask

  task automatic run_directed;
    send_word(32'sh8000_0000, 1'b1);
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh0, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sh0, 1'b0);
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh8000_0000, 1'b1);
    send_word(32'sd1, 1'b0);
    send_word(32'sd2, 1'b0);
    send_word(32'sd1, 1'b0);
    send_word(32'sd2, 1'b0);
    send_word(32'sd1, 1'b1);
    send_word(32'shAAAA_5555, 1'b0);
    send_word(32'sh5555_AAAA, 1'b1);
  endtask

  // fill all entries, then offer new words that must be dropped, the last one too, mixed with repeats that still count
  task automatic run_table_full;
    for (int k = 0; k < TABLE_DEPTH; k++) send_word(k - 32, 1'b0);
    send_word(32'sh1234_5678, 1'b0);
    send_word(-32'sd32, 1'b0);
    send_word(32'sd31, 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh7FFF_0000, 1'b1);
    // overflow must not leak into the next list
    send_word(-32'sd5, 1'b0);
    send_word(-32'sd5, 1'b1);
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_sample_value <= '0;
    in_ends_list    <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 14;
    rx_idle_pct = 46;
    run_directed();
    run_table_full();
    drain();
    run_random(table_tracker.words_noted + 90);
    drain();

    tx_idle_pct = 46;
    rx_idle_pct = 14;
    run_random(table_tracker.words_noted + 90);
    run_table_full();
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(table_tracker.words_noted + 70);
    in_valid <= 1'b0;
    @(posedge clk);
    while (table_tracker.pending() != 0) @(posedge clk);
    // let any stray entry show up before the verdict
    repeat (400) @(posedge clk);

    $display("%0d words in %0d lists sent, %0d table entries checked",
             table_tracker.words_noted, table_tracker.lists_closed,
             table_tracker.entries_checked);
    $display("%0d lists overflowed the table", table_tracker.overflow_lists);
    if (table_tracker.errors == 0 && table_tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* distinct_value_frequency_table_core.f */
rtl/dvft_pkg.sv
rtl/dvft_ram.sv
rtl/distinct_value_frequency_table_core.sv
dv/tb.sv
